// ===== rtl/grc_pkg.sv =====
// shared types and constants for the grid ray caster
package grc_pkg;

  // map size defaults and queue depth
  localparam int unsigned MAP_WIDTH_DEF  = 256;
  localparam int unsigned MAP_HEIGHT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // field widths
  localparam int unsigned COORD_W   = 13;
  localparam int unsigned WALK_W    = 14;
  localparam int unsigned DELTA_W   = 13;
  localparam int unsigned ERR_W     = 16;
  localparam int unsigned STEP_W    = 14;
  localparam int unsigned DIST_W    = 27;
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned STATE_W   = 2;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // largest stored extent per axis, cell writes carry 8-bit coordinates
  localparam int unsigned STORE_MAX = 256;

  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 1'b1;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_RAY   = 1'b1;

  // cell codes
  localparam logic [STATE_W-1:0] CELL_FREE    = 2'd0;
  localparam logic [STATE_W-1:0] CELL_UNKNOWN = 2'd1;

  // classified item, coordinates already in major/minor order
  typedef struct packed {
    logic                      is_ray;
    logic                      wr_en;
    logic [CELL_W-1:0]         cell_x;
    logic [CELL_W-1:0]         cell_y;
    logic [STATE_W-1:0]        cell_state;
    logic                      steep;
    logic signed [WALK_W-1:0]  maj0;
    logic signed [WALK_W-1:0]  min0;
    logic signed [WALK_W-1:0]  maj_end;
    logic [DELTA_W-1:0]        dx;
    logic [DELTA_W-1:0]        dy;
    logic                      xs_neg;
    logic                      ys_neg;
  } item_t;

endpackage

// ===== rtl/grc_front.sv =====
// front end: classifies input items and sets up the line walk
module grc_front #(
  parameter int unsigned MapWidth  = grc_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MapHeight = grc_pkg::MAP_HEIGHT_DEF
) (
  input  logic                                 kind_i,
  input  logic [grc_pkg::CELL_W-1:0]           cell_x_i,
  input  logic [grc_pkg::CELL_W-1:0]           cell_y_i,
  input  logic [grc_pkg::STATE_W-1:0]          cell_state_i,
  input  logic signed [grc_pkg::COORD_W-1:0]   start_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0]   start_y_i,
  input  logic signed [grc_pkg::COORD_W-1:0]   end_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0]   end_y_i,
  output grc_pkg::item_t                       item_o
);

  logic signed [grc_pkg::WALK_W-1:0] sx, sy, ex, ey;
  logic signed [grc_pkg::WALK_W-1:0] ddx, ddy, dmaj, dmin, maj1;
  logic [grc_pkg::DELTA_W-1:0]       adx, ady;
  logic                              steep;
  logic                              xs_neg;

  assign sx = {start_x_i[grc_pkg::COORD_W-1], start_x_i};
  assign sy = {start_y_i[grc_pkg::COORD_W-1], start_y_i};
  assign ex = {end_x_i[grc_pkg::COORD_W-1], end_x_i};
  assign ey = {end_y_i[grc_pkg::COORD_W-1], end_y_i};

  assign ddx = ex - sx;
  assign ddy = ey - sy;

  always_comb begin
    logic signed [grc_pkg::WALK_W-1:0] nx, ny;
    nx  = -ddx;
    ny  = -ddy;
    adx = ddx[grc_pkg::WALK_W-1] ? nx[grc_pkg::DELTA_W-1:0] : ddx[grc_pkg::DELTA_W-1:0];
    ady = ddy[grc_pkg::WALK_W-1] ? ny[grc_pkg::DELTA_W-1:0] : ddy[grc_pkg::DELTA_W-1:0];
  end

  assign steep  = ady > adx;
  assign dmaj   = steep ? ddy : ddx;
  assign dmin   = steep ? ddx : ddy;
  assign maj1   = steep ? ey : ex;
  // step is negative unless the end lies strictly ahead
  assign xs_neg = dmaj[grc_pkg::WALK_W-1] | (dmaj == '0);

  always_comb begin
    item_o.is_ray     = (kind_i == grc_pkg::KIND_RAY);
    item_o.wr_en      = (32'(cell_x_i) < MapWidth) && (32'(cell_y_i) < MapHeight);
    item_o.cell_x     = cell_x_i;
    item_o.cell_y     = cell_y_i;
    item_o.cell_state = cell_state_i;
    item_o.steep      = steep;
    item_o.maj0       = steep ? sy : sx;
    item_o.min0       = steep ? sx : sy;
    item_o.maj_end    = xs_neg ? maj1 - 14'sd1 : maj1 + 14'sd1;
    item_o.dx         = steep ? ady : adx;
    item_o.dy         = steep ? adx : ady;
    item_o.xs_neg     = xs_neg;
    item_o.ys_neg     = dmin[grc_pkg::WALK_W-1] | (dmin == '0);
  end

endmodule

// ===== rtl/grc_fifo.sv =====
// short item queue between front end and walker
module grc_fifo #(
  parameter int unsigned Depth = grc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  grc_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output grc_pkg::item_t data_o
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  grc_pkg::item_t    mem_q [Depth];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/grc_back.sv =====
// back end: map store, clearing pass, line walker and result register
module grc_back #(
  parameter int unsigned MapWidth  = grc_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MapHeight = grc_pkg::MAP_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grc_pkg::item_t                      entry_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  input  logic [grc_pkg::CFG_W-1:0]           width_cfg_i,
  input  logic [grc_pkg::CFG_W-1:0]           height_cfg_i,
  output logic                                clearing_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                hit_o,
  output logic [grc_pkg::DIST_W-1:0]          dist_sq_o,
  output logic signed [grc_pkg::COORD_W-1:0]  hit_x_o,
  output logic signed [grc_pkg::COORD_W-1:0]  hit_y_o
);

  localparam int unsigned STORE_W = (MapWidth < grc_pkg::STORE_MAX) ? MapWidth
                                                                     : grc_pkg::STORE_MAX;
  localparam int unsigned STORE_H = (MapHeight < grc_pkg::STORE_MAX) ? MapHeight
                                                                      : grc_pkg::STORE_MAX;
  localparam int unsigned XW      = $clog2(STORE_W);
  localparam int unsigned YW      = $clog2(STORE_H);
  localparam int unsigned ADDR_W  = XW + YW;
  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam int unsigned CW      = grc_pkg::COORD_W;
  localparam int unsigned WW      = grc_pkg::WALK_W;
  localparam int unsigned SQ_W    = 2 * grc_pkg::STEP_W;
  localparam logic [grc_pkg::CFG_W-1:0] STORE_W_CFG = grc_pkg::CFG_W'(STORE_W);
  localparam logic [grc_pkg::CFG_W-1:0] STORE_H_CFG = grc_pkg::CFG_W'(STORE_H);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_SQ    = 5'b01000,
    S_SUM   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // map store
  logic [grc_pkg::STATE_W-1:0] map_q [DEPTH];
  logic [grc_pkg::STATE_W-1:0] rd_q;
  logic [ADDR_W-1:0]           rd_addr, mem_waddr, clr_q, clr_d;
  logic [grc_pkg::STATE_W-1:0] mem_wdata;
  logic                        mem_we;

  // current item and walk state
  grc_pkg::item_t                 cur_q, cur_d;
  logic signed [WW-1:0]           ix_q, ix_d, iy_q, iy_d;
  logic signed [grc_pkg::ERR_W-1:0] err_q, err_d, err_add;
  logic [grc_pkg::STEP_W-1:0]     imaj_q, imaj_d, imin_q, imin_d;
  logic                           iss_live_q, iss_live_d;

  // check stage
  logic                           chk_v_q, chk_v_d;
  logic signed [WW-1:0]           cux_q, cux_d, cuy_q, cuy_d;
  logic [grc_pkg::STEP_W-1:0]     cmaj_q, cmaj_d, cmin_q, cmin_d;
  logic                           coff_q, coff_d, clast_q, clast_d;

  // result path
  logic [grc_pkg::DIST_W-1:0]     sq_q, sq_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_hit_q, out_hit_d;
  logic [grc_pkg::DIST_W-1:0]     out_dist_q, out_dist_d;
  logic signed [CW-1:0]           out_hx_q, out_hx_d, out_hy_q, out_hy_d;

  logic [grc_pkg::CFG_W-1:0]      lim_w, lim_h;
  logic signed [WW-1:0]           ux, uy;
  logic                           iss_off, iss_last, step_min, blocked, out_free;
  logic [SQ_W-1:0]                maj_sq, min_sq;

  // the in-use limits are clamped to the stored extent, so cells past it block like off-map cells
  assign lim_w = (width_cfg_i < STORE_W_CFG) ? width_cfg_i : STORE_W_CFG;
  assign lim_h = (height_cfg_i < STORE_H_CFG) ? height_cfg_i : STORE_H_CFG;

  assign ux       = cur_q.steep ? iy_q : ix_q;
  assign uy       = cur_q.steep ? ix_q : iy_q;
  assign iss_off  = ux[WW-1] | (ux[CW-1:0] >= CW'(lim_w)) |
                    uy[WW-1] | (uy[CW-1:0] >= CW'(lim_h));
  assign iss_last = (ix_q == cur_q.maj_end);
  assign rd_addr  = {uy[YW-1:0], ux[XW-1:0]};

  assign err_add  = err_q + $signed({3'b000, cur_q.dy});
  assign step_min = $signed({err_add, 1'b0}) >= $signed({4'b0000, cur_q.dx});

  assign blocked  = coff_q | (rd_q != grc_pkg::CELL_FREE);
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i && out_free;

  assign maj_sq   = cmaj_q * cmaj_q;
  assign min_sq   = cmin_q * cmin_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = grc_pkg::CELL_UNKNOWN;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (pop_o && !entry_i.is_ray && entry_i.wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = {entry_i.cell_y[YW-1:0], entry_i.cell_x[XW-1:0]};
      mem_wdata = entry_i.cell_state;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    ix_d        = ix_q;
    iy_d        = iy_q;
    err_d       = err_q;
    imaj_d      = imaj_q;
    imin_d      = imin_q;
    iss_live_d  = iss_live_q;
    chk_v_d     = chk_v_q;
    cux_d       = cux_q;
    cuy_d       = cuy_q;
    cmaj_d      = cmaj_q;
    cmin_d      = cmin_q;
    coff_d      = coff_q;
    clast_d     = clast_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hit_d   = out_hit_q;
    out_dist_d  = out_dist_q;
    out_hx_d    = out_hx_q;
    out_hy_d    = out_hy_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_o) begin
          if (entry_i.is_ray) begin
            cur_d      = entry_i;
            ix_d       = entry_i.maj0;
            iy_d       = entry_i.min0;
            err_d      = '0;
            imaj_d     = '0;
            imin_d     = '0;
            iss_live_d = 1'b1;
            chk_v_d    = 1'b0;
            state_d    = S_WALK;
          end else begin
            out_valid_d = 1'b1;
            out_hit_d   = 1'b0;
            out_dist_d  = '0;
            out_hx_d    = '0;
            out_hy_d    = '0;
          end
        end
      end
      S_WALK: begin
        // issue side runs one cell ahead of the check side
        if (iss_live_q) begin
          chk_v_d = 1'b1;
          cux_d   = ux;
          cuy_d   = uy;
          coff_d  = iss_off;
          clast_d = iss_last;
          cmaj_d  = imaj_q;
          cmin_d  = imin_q;
          if (iss_last) begin
            iss_live_d = 1'b0;
          end else begin
            ix_d   = cur_q.xs_neg ? ix_q - 14'sd1 : ix_q + 14'sd1;
            imaj_d = imaj_q + 1'b1;
            if (step_min) begin
              iy_d   = cur_q.ys_neg ? iy_q - 14'sd1 : iy_q + 14'sd1;
              err_d  = err_add - $signed({3'b000, cur_q.dx});
              imin_d = imin_q + 1'b1;
            end else begin
              err_d = err_add;
            end
          end
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q) begin
          if (blocked) begin
            // drop the cell already issued and keep the step counts of the stop cell
            iss_live_d = 1'b0;
            chk_v_d    = 1'b0;
            cmaj_d     = cmaj_q;
            cmin_d     = cmin_q;
            out_hx_d   = cux_q[CW-1:0];
            out_hy_d   = cuy_q[CW-1:0];
            state_d    = S_SQ;
          end else if (clast_q) begin
            out_valid_d = 1'b1;
            out_hit_d   = 1'b0;
            out_dist_d  = '0;
            out_hx_d    = '0;
            out_hy_d    = '0;
            state_d     = S_IDLE;
          end
        end
      end
      S_SQ: begin
        sq_d    = maj_sq[grc_pkg::DIST_W-1:0];
        state_d = S_SUM;
      end
      S_SUM: begin
        out_valid_d = 1'b1;
        out_hit_d   = 1'b1;
        out_dist_d  = sq_q + min_sq[grc_pkg::DIST_W-1:0];
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      iss_live_q  <= 1'b0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_live_q  <= iss_live_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    ix_q       <= ix_d;
    iy_q       <= iy_d;
    err_q      <= err_d;
    imaj_q     <= imaj_d;
    imin_q     <= imin_d;
    cux_q      <= cux_d;
    cuy_q      <= cuy_d;
    cmaj_q     <= cmaj_d;
    cmin_q     <= cmin_d;
    coff_q     <= coff_d;
    clast_q    <= clast_d;
    sq_q       <= sq_d;
    out_hit_q  <= out_hit_d;
    out_dist_q <= out_dist_d;
    out_hx_q   <= out_hx_d;
    out_hy_q   <= out_hy_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= map_q[rd_addr];
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign dist_sq_o   = out_dist_q;
  assign hit_x_o     = out_hx_q;
  assign hit_y_o     = out_hy_q;

  a_pop_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> out_free)
    else $error("item taken from queue while result register is occupied");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("map write outside clear or idle");

  a_block_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && chk_v_q && blocked) |=> (state_q == S_SQ))
    else $error("blocked cell did not end the walk");

  a_minor_le_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_v_q |-> (cmin_q <= cmaj_q))
    else $error("minor step count ran ahead of major count");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (dist_sq_o == '0 && hit_x_o == '0 && hit_y_o == '0))
    else $error("non-hit result carries nonzero fields");

endmodule

// ===== rtl/grid_ray_cast.sv =====
// top level of the grid ray caster: config registers, front end, queue, walker
//
//  channel   direction  handshake                   payload
//  in        input      in_valid_i / in_ready_o     kind, cell_x/y, cell_state, start/end x/y
//  out       output     out_valid_o / out_ready_i   hit, dist_sq, hit_x, hit_y
//  cfg       input      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// a write item is popped and written in the same cycle; a ray is popped, then its cells
// issue one per cycle, each map read registered and checked as the next cell issues; a
// ray that stops on a blocked cell then forms its squared distance in S_SQ and S_SUM, and
// one that runs clear ends when its last cell checks free. after reset the walker sweeps
// the map to unknown, one cell per cycle (65536 cells by default); no item is taken then.
// a two-entry queue lets the input side keep taking items while the walker is busy;
// the walker takes the next item only once the result register is empty or draining.
module grid_ray_cast #(
  parameter int unsigned MapWidth   = grc_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MapHeight  = grc_pkg::MAP_HEIGHT_DEF,
  parameter int unsigned QueueDepth = grc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [grc_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [grc_pkg::CELL_W-1:0]          cell_x_i,
  input  logic [grc_pkg::CELL_W-1:0]          cell_y_i,
  input  logic [grc_pkg::STATE_W-1:0]         cell_state_i,
  input  logic signed [grc_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [grc_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0]  end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [grc_pkg::DIST_W-1:0]          dist_sq_o,
  output logic signed [grc_pkg::COORD_W-1:0]  hit_x_o,
  output logic signed [grc_pkg::COORD_W-1:0]  hit_y_o
);

  logic [grc_pkg::CFG_W-1:0] width_q, width_d, height_q, height_d;
  grc_pkg::item_t            front_item, queue_item;
  logic                      queue_full, queue_empty, queue_pop, push, clearing;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        grc_pkg::REG_WIDTH_IN_USE:  width_d  = cfg_wdata_i;
        grc_pkg::REG_HEIGHT_IN_USE: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= grc_pkg::CFG_SIZE_RST;
      height_q <= grc_pkg::CFG_SIZE_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign in_ready_o = !queue_full && !clearing;
  assign push       = in_valid_i && in_ready_o;

  grc_front #(
    .MapWidth  (MapWidth),
    .MapHeight (MapHeight)
  ) u_front (
    .kind_i       (kind_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_state_i (cell_state_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .item_o       (front_item)
  );

  grc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .data_o  (queue_item)
  );

  grc_back #(
    .MapWidth  (MapWidth),
    .MapHeight (MapHeight)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (queue_item),
    .empty_i      (queue_empty),
    .pop_o        (queue_pop),
    .width_cfg_i  (width_q),
    .height_cfg_i (height_q),
    .clearing_o   (clearing),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .hit_o        (hit_o),
    .dist_sq_o    (dist_sq_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o)
  );

endmodule
